// ----- hdl/yima_pkg.sv -----
// shared types and fixed constants for the yaw integrate moving average unit
`timescale 1ns / 1ps
`default_nettype none
package yima_pkg;

  // item field types
  typedef logic signed [18:0] rate_t;
  typedef logic        [15:0] ms_t;
  typedef logic signed [15:0] sample_t;
  typedef logic        [17:0] deadband_t;

  // six stored channels, in history row order
  localparam int unsigned CH = 6;
  localparam int unsigned CH_AX    = 0;
  localparam int unsigned CH_AY    = 1;
  localparam int unsigned CH_AZ    = 2;
  localparam int unsigned CH_ROLL  = 3;
  localparam int unsigned CH_PITCH = 4;
  localparam int unsigned CH_YAW   = 5;

  typedef sample_t [CH-1:0] hist_row_t;

  localparam deadband_t DEADBAND_RST = 18'd128;

  // half and full turn in 1/128 degree
  localparam sample_t                HALF_ANGLE = 16'sd23040;
  localparam logic signed [16:0]     HALF_TURN  = 17'sd23040;
  localparam logic signed [16:0]     FULL_TURN  = 17'sd46080;
  localparam logic        [14:0]     STEP_MAX   = 15'd23040;

  // rate * ms at or above this gives a step beyond half a turn
  localparam logic [33:0] STEP_LIMIT = 34'd23041000;

  // divide by 1000: exact for dividends below 2^25
  localparam logic [25:0] RECIP_1000 = 26'd34359739;
  localparam int unsigned RSH_1000   = 35;

  // accel scale: a * 981 / 1600 = ((a * 981) >> 6) / 25
  localparam logic [9:0]  ACC_SCALE  = 10'd981;
  localparam int unsigned ACC_PRE_SH = 6;
  localparam logic [19:0] RECIP_25   = 20'd671089;
  localparam int unsigned RSH_25     = 24;

endpackage
`default_nettype wire

// ----- hdl/yima_if.sv -----
// valid/ready channel interfaces for sample items and result items
`timescale 1ns / 1ps
`default_nettype none
interface yima_in_if import yima_pkg::*; ();
  logic    valid;
  logic    ready;
  rate_t   gyro_rate_z;
  ms_t     elapsed_ms;
  sample_t accel_x_g;
  sample_t accel_y_g;
  sample_t accel_z_g;
  sample_t pitch_in;
  sample_t roll_in;

  modport source (
    output valid, gyro_rate_z, elapsed_ms, accel_x_g, accel_y_g, accel_z_g,
           pitch_in, roll_in,
    input  ready
  );
  modport sink (
    input  valid, gyro_rate_z, elapsed_ms, accel_x_g, accel_y_g, accel_z_g,
           pitch_in, roll_in,
    output ready
  );
endinterface

interface yima_out_if import yima_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t avg_accel_x;
  sample_t avg_accel_y;
  sample_t avg_accel_z;
  sample_t avg_roll;
  sample_t avg_pitch;
  sample_t avg_yaw;
  sample_t yaw_now;

  modport source (
    output valid, avg_accel_x, avg_accel_y, avg_accel_z, avg_roll, avg_pitch,
           avg_yaw, yaw_now,
    input  ready
  );
  modport sink (
    input  valid, avg_accel_x, avg_accel_y, avg_accel_z, avg_roll, avg_pitch,
           avg_yaw, yaw_now,
    output ready
  );
endinterface
`default_nettype wire

// ----- hdl/yaw_integrate_moving_average_unit.sv -----
// top level: gyro yaw integration, accel scaling and six-channel boxcar averages
`timescale 1ns / 1ps
`default_nettype none
// Takes one IMU sample item per clock when not stalled and returns one result
// item per sample, in order. A sample goes through four pipeline registers
// (input, products, quotients, running-sum update) and its result is then
// loaded into the output register; without stalls, throughput is one item
// per cycle, set by the single read-modify-write of the history row and the
// running sums. The history is a WINDOW-row memory of six 16-bit channels
// with one read and one write per cycle; a valid bit per row makes unwritten
// rows read as zero, so it is ready straight out of reset with no clearing pass.
// The yaw deadband register resets to 128 and is written through cfg_we with
// cfg_wdata; write it only while no item is in flight.
module yaw_integrate_moving_average_unit import yima_pkg::*; #(
  parameter int unsigned WINDOW = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      cfg_we,
  input  wire deadband_t cfg_wdata,
  yima_in_if.sink        in_item,
  yima_out_if.source     out_item
);

  localparam int unsigned PW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned LW    = $clog2(WINDOW);
  localparam int unsigned SUM_W = 16 + LW;
  localparam int unsigned RSH   = SUM_W - 1 + LW;
  localparam int unsigned RW    = SUM_W + 1;
  localparam int unsigned PRODW = SUM_W + RW;
  localparam logic [RW-1:0] RECIP_W =
    RW'(((64'd1 << RSH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
  localparam logic [PW-1:0] POS_LAST = PW'(WINDOW - 1);

  typedef logic signed [SUM_W-1:0] sum_t;

  // ---------------- handshake chain ----------------
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_v_r;
  logic out_load, s4_adv, s3_adv, s2_adv, s1_adv, in_acc;

  assign out_load = !out_v_r || out_item.ready;
  assign s4_adv   = s4_v_r && out_load;
  assign s3_adv   = s3_v_r && (!s4_v_r || s4_adv);
  assign s2_adv   = s2_v_r && (!s3_v_r || s3_adv);
  assign s1_adv   = s1_v_r && (!s2_v_r || s2_adv);
  assign in_item.ready = !s1_v_r || s1_adv;
  assign in_acc   = in_item.valid && in_item.ready;

  logic s1_v_nxt, s2_v_nxt, s3_v_nxt, s4_v_nxt, out_v_nxt;
  always_comb begin
    s1_v_nxt  = in_acc || (s1_v_r && !s1_adv);
    s2_v_nxt  = s1_adv || (s2_v_r && !s2_adv);
    s3_v_nxt  = s2_adv || (s3_v_r && !s3_adv);
    s4_v_nxt  = s3_adv || (s4_v_r && !s4_adv);
    out_v_nxt = s4_adv || (out_v_r && !out_item.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      s3_v_r  <= s3_v_nxt;
      s4_v_r  <= s4_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // ---------------- config and write position ----------------
  deadband_t     deadband_r;
  logic [PW-1:0] pos_r, pos_nxt;

  assign pos_nxt = (pos_r == POS_LAST) ? '0 : pos_r + PW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadband_r <= DEADBAND_RST;
      pos_r      <= '0;
    end else begin
      if (cfg_we) begin
        deadband_r <= cfg_wdata;
      end
      if (in_acc) begin
        pos_r <= pos_nxt;
      end
    end
  end

  // ---------------- stage 1: input register ----------------
  rate_t         s1_rate_r;
  ms_t           s1_ms_r;
  sample_t [2:0] s1_acc_r;
  sample_t       s1_pitch_r, s1_roll_r;
  logic [PW-1:0] s1_pos_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_rate_r   <= in_item.gyro_rate_z;
      s1_ms_r     <= in_item.elapsed_ms;
      s1_acc_r[0] <= in_item.accel_x_g;
      s1_acc_r[1] <= in_item.accel_y_g;
      s1_acc_r[2] <= in_item.accel_z_g;
      s1_pitch_r  <= in_item.pitch_in;
      s1_roll_r   <= in_item.roll_in;
      s1_pos_r    <= pos_r;
    end
  end

  // magnitudes and first products
  logic [18:0]       rate_mag;
  logic              integ_nxt;
  logic [33:0]       prod_nxt;
  logic [2:0]        acc_neg_nxt;
  logic [2:0][24:0]  acc_p_nxt;
  logic [15:0]       acc_mag;

  always_comb begin
    rate_mag  = s1_rate_r[18] ? 19'(-s1_rate_r) : 19'(s1_rate_r);
    integ_nxt = rate_mag > {1'b0, deadband_r};
    prod_nxt  = 34'(rate_mag) * 34'(s1_ms_r);
    acc_mag   = '0;
    for (int c = 0; c < 3; c++) begin
      acc_neg_nxt[c] = s1_acc_r[c][15];
      acc_mag        = s1_acc_r[c][15] ? 16'(-s1_acc_r[c]) : 16'(s1_acc_r[c]);
      acc_p_nxt[c]   = 25'(acc_mag) * 25'(ACC_SCALE);
    end
  end

  // ---------------- stage 2: products ----------------
  logic             s2_integ_r, s2_rneg_r;
  logic [33:0]      s2_prod_r;
  logic [2:0]       s2_acc_neg_r;
  logic [2:0][24:0] s2_acc_p_r;
  sample_t          s2_pitch_r, s2_roll_r;
  logic [PW-1:0]    s2_pos_r;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_integ_r   <= integ_nxt;
      s2_rneg_r    <= s1_rate_r[18];
      s2_prod_r    <= prod_nxt;
      s2_acc_neg_r <= acc_neg_nxt;
      s2_acc_p_r   <= acc_p_nxt;
      s2_pitch_r   <= s1_pitch_r;
      s2_roll_r    <= s1_roll_r;
      s2_pos_r     <= s1_pos_r;
    end
  end

  // quotients by reciprocal multiply
  logic [50:0]      p1000;
  logic [14:0]      step_mag;
  sample_t          step_nxt;
  logic [38:0]      p25;
  logic [14:0]      acc_q;
  sample_t [2:0]    acc_val_nxt;

  always_comb begin
    p1000    = 51'(s2_prod_r[24:0]) * 51'(RECIP_1000);
    // a step beyond half a turn clamps, so only the small case is divided
    step_mag = (s2_prod_r >= STEP_LIMIT) ? STEP_MAX : p1000[RSH_1000 +: 15];
    step_nxt = s2_rneg_r ? -$signed({1'b0, step_mag}) : $signed({1'b0, step_mag});
    p25      = '0;
    acc_q    = '0;
    for (int c = 0; c < 3; c++) begin
      p25   = 39'(s2_acc_p_r[c][24:ACC_PRE_SH]) * 39'(RECIP_25);
      acc_q = p25[RSH_25 +: 15];
      acc_val_nxt[c] = s2_acc_neg_r[c] ? -$signed({1'b0, acc_q})
                                       : $signed({1'b0, acc_q});
    end
  end

  // ---------------- history memory ----------------
  hist_row_t            hist_mem [WINDOW];
  logic [WINDOW-1:0]    hist_vld_r;
  hist_row_t            rd_row_r;
  logic                 rd_vld_r;
  hist_row_t            wr_row;

  // ---------------- stage 3: quotients ----------------
  logic          s3_integ_r;
  sample_t       s3_step_r;
  sample_t [2:0] s3_acc_r;
  sample_t       s3_pitch_r, s3_roll_r;
  logic [PW-1:0] s3_pos_r;

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      s3_integ_r <= s2_integ_r;
      s3_step_r  <= step_nxt;
      s3_acc_r   <= acc_val_nxt;
      s3_pitch_r <= s2_pitch_r;
      s3_roll_r  <= s2_roll_r;
      s3_pos_r   <= s2_pos_r;
      // old row for this item, read one stage ahead of its update
      rd_row_r   <= hist_mem[s2_pos_r];
      rd_vld_r   <= hist_vld_r[s2_pos_r];
    end
  end

  always_ff @(posedge clk) begin
    if (s3_adv) begin
      hist_mem[s3_pos_r] <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_vld_r <= '0;
    end else if (s3_adv) begin
      hist_vld_r[s3_pos_r] <= 1'b1;
    end
  end

  // yaw update and running sums
  sample_t            yaw_r, yaw_nxt;
  sum_t [CH-1:0]      sums_r, sums_nxt;
  logic signed [16:0] yaw_sum;
  hist_row_t          old_row;

  always_comb begin
    yaw_sum = {yaw_r[15], yaw_r} + {s3_step_r[15], s3_step_r};
    yaw_nxt = yaw_r;
    if (s3_integ_r) begin
      if (yaw_sum >= HALF_TURN) begin
        yaw_nxt = 16'(yaw_sum - FULL_TURN);
      end else if (yaw_sum < -HALF_TURN) begin
        yaw_nxt = 16'(yaw_sum + FULL_TURN);
      end else begin
        yaw_nxt = 16'(yaw_sum);
      end
    end
    wr_row[CH_AX]    = s3_acc_r[0];
    wr_row[CH_AY]    = s3_acc_r[1];
    wr_row[CH_AZ]    = s3_acc_r[2];
    wr_row[CH_ROLL]  = s3_roll_r;
    wr_row[CH_PITCH] = s3_pitch_r;
    wr_row[CH_YAW]   = yaw_nxt;
    // a row never written counts as zero
    old_row = rd_vld_r ? rd_row_r : '0;
    for (int c = 0; c < CH; c++) begin
      sums_nxt[c] = sums_r[c] + {{LW{wr_row[c][15]}}, wr_row[c]}
                              - {{LW{old_row[c][15]}}, old_row[c]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yaw_r  <= '0;
      sums_r <= '0;
    end else if (s3_adv) begin
      yaw_r  <= yaw_nxt;
      sums_r <= sums_nxt;
    end
  end

  // ---------------- stage 4 to output: averages ----------------
  logic [SUM_W-1:0] sum_mag;
  logic [PRODW-1:0] avg_p;
  logic [15:0]      avg_q;
  sample_t [CH-1:0] avg_nxt, avg_r;
  sample_t          yaw_out_r;

  always_comb begin
    sum_mag = '0;
    avg_p   = '0;
    avg_q   = '0;
    for (int c = 0; c < CH; c++) begin
      sum_mag    = sums_r[c][SUM_W-1] ? SUM_W'(-sums_r[c]) : SUM_W'(sums_r[c]);
      avg_p      = PRODW'(sum_mag) * PRODW'(RECIP_W);
      avg_q      = avg_p[RSH +: 16];
      avg_nxt[c] = sums_r[c][SUM_W-1] ? -$signed(avg_q) : $signed(avg_q);
    end
  end

  always_ff @(posedge clk) begin
    if (s4_adv) begin
      avg_r     <= avg_nxt;
      yaw_out_r <= yaw_r;
    end
  end

  assign out_item.valid       = out_v_r;
  assign out_item.avg_accel_x = avg_r[CH_AX];
  assign out_item.avg_accel_y = avg_r[CH_AY];
  assign out_item.avg_accel_z = avg_r[CH_AZ];
  assign out_item.avg_roll    = avg_r[CH_ROLL];
  assign out_item.avg_pitch   = avg_r[CH_PITCH];
  assign out_item.avg_yaw     = avg_r[CH_YAW];
  assign out_item.yaw_now     = yaw_out_r;

`ifndef SYNTHESIS
  a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
    (yaw_r >= -HALF_ANGLE) && (yaw_r < HALF_ANGLE))
    else $error("yaw left the half-open turn range");

  a_pos_order: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && s3_v_r) |->
      (s2_pos_r == ((s3_pos_r == POS_LAST) ? PW'(0) : s3_pos_r + PW'(1))))
    else $error("history rows out of order between pipeline stages");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s4_v_r && out_v_r && !out_item.ready) |=> s4_v_r)
    else $error("item lost behind a stalled output");

  a_row_marked: assert property (@(posedge clk) disable iff (!rst_n)
    s3_adv |=> hist_vld_r[$past(s3_pos_r)])
    else $error("written history row not marked valid");
`endif

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
// self-checking testbench for the yaw integrate moving average unit
`timescale 1ns / 1ps
module testbench;
  import yima_pkg::*;

  localparam int WINDOW_LEN     = 16;
  localparam int DRAIN_CYCLES   = 12;
  localparam int STALL_LIMIT    = 4000;
  localparam int LONG_HOLD      = 300;
  localparam int MAX_REPORTS    = 10;
  localparam longint HALF_TURN_Q = 23040;
  localparam longint FULL_TURN_Q = 46080;

  typedef struct packed {
    rate_t   rate;
    ms_t     ms;
    sample_t ax;
    sample_t ay;
    sample_t az;
    sample_t pitch;
    sample_t roll;
  } sample_item_t;

  typedef struct packed {
    hist_row_t avg;
    sample_t   yaw_now;
  } avg_result_t;

  logic      clk;
  logic      rst_n;
  logic      cfg_we;
  deadband_t cfg_wdata;

  yima_in_if  in_item ();
  yima_out_if out_item ();

  yaw_integrate_moving_average_unit #(
    .WINDOW(WINDOW_LEN)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_item  (in_item),
    .out_item (out_item)
  );

  // own copy of the block state
  deadband_t deadband_q;
  longint    yaw_q;
  int        ring_pos;
  longint    ring [CH][WINDOW_LEN];
  longint    chan_sum [CH];

  avg_result_t pending_averages[$];

  int  samples_sent;
  int  results_checked;
  int  mismatches;
  int  settings_used;
  int  stall_cycles;
  int  sink_hold_req;
  bit  src_idle;
  bit  sink_idle;

  string chan_name [CH] = '{"avg_accel_x", "avg_accel_y", "avg_accel_z",
                            "avg_roll", "avg_pitch", "avg_yaw"};

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void clear_history();
    yaw_q    = 0;
    ring_pos = 0;
    for (int c = 0; c < CH; c++) begin
      chan_sum[c] = 0;
      for (int w = 0; w < WINDOW_LEN; w++) ring[c][w] = 0;
    end
  endfunction

  function automatic avg_result_t integrate_and_average(sample_item_t s);
    longint      rate;
    longint      mag;
    longint      step;
    longint      y;
    longint      chan [CH];
    avg_result_t r;
    rate = s.rate;
    mag  = (rate < 0) ? -rate : rate;
    if (mag > longint'(deadband_q)) begin
      step = (rate * longint'(s.ms)) / 1000;
      if (step > HALF_TURN_Q) step = HALF_TURN_Q;
      if (step < -HALF_TURN_Q) step = -HALF_TURN_Q;
      y = yaw_q + step;
      if (y >= HALF_TURN_Q) y = y - FULL_TURN_Q;
      else if (y < -HALF_TURN_Q) y = y + FULL_TURN_Q;
      yaw_q = y;
    end
    // 1/2048 g to 1/128 m/s^2
    chan[CH_AX]    = (longint'(s.ax) * 981) / 1600;
    chan[CH_AY]    = (longint'(s.ay) * 981) / 1600;
    chan[CH_AZ]    = (longint'(s.az) * 981) / 1600;
    chan[CH_ROLL]  = s.roll;
    chan[CH_PITCH] = s.pitch;
    chan[CH_YAW]   = yaw_q;
    for (int c = 0; c < CH; c++) begin
      chan_sum[c]       = chan_sum[c] + chan[c] - ring[c][ring_pos];
      ring[c][ring_pos] = chan[c];
      r.avg[c]          = sample_t'(chan_sum[c] / WINDOW_LEN);
    end
    ring_pos  = (ring_pos + 1) % WINDOW_LEN;
    r.yaw_now = sample_t'(yaw_q);
    return r;
  endfunction

  function automatic sample_item_t make_sample(int rate, int ms, int ax, int ay, int az,
                                               int pitch, int roll);
    sample_item_t s;
    s.rate  = rate_t'(rate);
    s.ms    = ms_t'(ms);
    s.ax    = sample_t'(ax);
    s.ay    = sample_t'(ay);
    s.az    = sample_t'(az);
    s.pitch = sample_t'(pitch);
    s.roll  = sample_t'(roll);
    return s;
  endfunction

  function automatic sample_t random_angle();
    if ($urandom_range(0, 7) == 0) return sample_t'($urandom);
    return sample_t'(int'($urandom_range(0, 46080)) - 23040);
  endfunction

  function automatic sample_item_t random_sample();
    sample_item_t s;
    int           v;
    case ($urandom_range(0, 9))
      0, 1: s.rate = rate_t'($urandom);
      2: begin
        case ($urandom_range(0, 2))
          0: s.rate = rate_t'(-262144);
          1: s.rate = rate_t'(262143);
          default: s.rate = '0;
        endcase
      end
      3, 4: begin
        // rates straddling the deadband
        v = int'(deadband_q) + int'($urandom_range(0, 2)) - 1;
        if (v > 262143) v = 262143;
        if (v < 0) v = 0;
        s.rate = rate_t'($urandom_range(0, 1) ? -v : v);
      end
      default: s.rate = rate_t'(int'($urandom_range(0, 60000)) - 30000);
    endcase
    case ($urandom_range(0, 7))
      0: s.ms = ms_t'($urandom);
      1: s.ms = '0;
      default: s.ms = ms_t'($urandom_range(1, 100));
    endcase
    s.ax    = sample_t'($urandom);
    s.ay    = sample_t'($urandom);
    s.az    = sample_t'($urandom);
    s.pitch = random_angle();
    s.roll  = random_angle();
    return s;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_sample(input sample_item_t s);
    int gap;
    gap = src_idle ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_item.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item.gyro_rate_z = s.rate;
    in_item.elapsed_ms  = s.ms;
    in_item.accel_x_g   = s.ax;
    in_item.accel_y_g   = s.ay;
    in_item.accel_z_g   = s.az;
    in_item.pitch_in    = s.pitch;
    in_item.roll_in     = s.roll;
    in_item.valid       = 1'b1;
    do @(posedge clk); while (in_item.ready !== 1'b1);
    pending_averages.push_back(integrate_and_average(s));
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) send_sample(random_sample());
  endtask

  task automatic wait_drained();
    in_item.valid = 1'b0;
    while (pending_averages.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_deadband(input deadband_t value);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we     = 1'b0;
    deadband_q = value;
    settings_used++;
  endtask

  // reset deadband, cleared history ramp, clamp and wrap edges, accel rounding
  task automatic test_directed_edges();
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    send_sample(make_sample(0, 0, 0, 0, 0, 0, 0));
    send_sample(make_sample(128, 1000, 32767, -32768, -1, 23040, -23040));
    send_sample(make_sample(-128, 1000, 1, -2, 2, -23040, 23040));
    send_sample(make_sample(129, 1000, -32768, 32767, 0, 0, 0));
    send_sample(make_sample(-129, 1000, 1600, -1600, 1599, 32767, -32768));
    send_sample(make_sample(262143, 65535, 32767, 32767, 32767, -32768, 32767));
    send_sample(make_sample(-262144, 65535, -32768, -32768, -32768, 23040, 23040));
    send_sample(make_sample(23040, 1000, 0, 0, 0, -23040, -23040));
    // one below minus half a turn wraps to the top of the range
    send_sample(make_sample(-1000, 1, 3, -3, 5, 100, -100));
    send_sample(make_sample(1000, 1, -5, 7, -7, 0, 0));
    send_sample(make_sample(-999, 1, 0, 0, 0, 0, 0));
    send_sample(make_sample(200, 65535, 12345, -12345, 2048, 11520, -11520));
    send_sample(make_sample(-200, 65535, -2048, 2048, -2048, -11520, 11520));
    send_sample(make_sample(262143, 0, 0, 0, 0, 0, 0));
    send_sample(make_sample(-262144, 1, 0, 0, 0, 0, 0));
    send_sample(make_sample(129, 65535, 1, 1, 1, 1, 1));
    wait_drained();
  endtask

  // deadband register at its extremes and a few points between
  task automatic test_deadband_sweep();
    deadband_t points [6];
    points = '{18'd0, 18'd262143, 18'd1, 18'd262142, 18'd128, deadband_t'($urandom)};
    src_idle  = 1'b0;
    sink_idle = 1'b1;
    foreach (points[p]) begin
      set_deadband(points[p]);
      if (points[p] == 18'd0) begin
        send_sample(make_sample(0, 1000, 0, 0, 0, 0, 0));
        send_sample(make_sample(1, 1000, 0, 0, 0, 0, 0));
        send_sample(make_sample(-1, 1000, 0, 0, 0, 0, 0));
      end else if (points[p] == 18'd262143) begin
        send_sample(make_sample(262143, 1000, 0, 0, 0, 0, 0));
        send_sample(make_sample(-262144, 1000, 0, 0, 0, 0, 0));
      end
      send_random(40);
      src_idle = ~src_idle;
      wait_drained();
    end
  endtask

  // output held off for a long stretch while items keep coming
  task automatic test_backpressure_fill();
    src_idle      = 1'b0;
    sink_idle     = 1'b0;
    sink_hold_req = LONG_HOLD;
    send_random(60);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    for (int k = 0; k < 11; k++) begin
      src_idle  = (k % 3) != 0;
      sink_idle = (k % 4) != 1;
      if ($urandom_range(0, 3) == 0) set_deadband(deadband_t'($urandom));
      else set_deadband(deadband_t'($urandom_range(0, 2000)));
      send_random(150);
      wait_drained();
    end
  endtask

  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    in_item.valid       = 1'b0;
    in_item.gyro_rate_z = '0;
    in_item.elapsed_ms  = '0;
    in_item.accel_x_g   = '0;
    in_item.accel_y_g   = '0;
    in_item.accel_z_g   = '0;
    in_item.pitch_in    = '0;
    in_item.roll_in     = '0;
    src_idle            = 1'b0;
    sink_idle           = 1'b0;
    sink_hold_req       = 0;
    samples_sent        = 0;
    results_checked     = 0;
    mismatches          = 0;
    settings_used       = 0;
    deadband_q          = DEADBAND_RST;
    clear_history();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed_edges();
    test_deadband_sweep();
    test_backpressure_fill();
    test_random_traffic();

    wait_drained();
    $display("%0d samples sent, %0d results checked, %0d deadband settings written",
             samples_sent, results_checked, settings_used);
    $display("covered deadband edges, yaw clamp and wrap, history ramp, long output stall");
    if (mismatches == 0 && pending_averages.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // result side: random hold-off per item, plus one long hold when asked
  initial begin
    int gap;
    out_item.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      gap = sink_idle ? $urandom_range(0, 16) : 0;
      if (sink_hold_req > 0) begin
        gap           = sink_hold_req;
        sink_hold_req = 0;
      end
      if (gap > 0) begin
        out_item.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_item.ready = 1'b1;
      do @(posedge clk); while (out_item.valid !== 1'b1);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : check_result
    avg_result_t got;
    avg_result_t want;
    bit          bad;
    if (rst_n === 1'b1 && out_item.valid === 1'b1 && out_item.ready === 1'b1) begin
      results_checked++;
      got.avg[CH_AX]    = out_item.avg_accel_x;
      got.avg[CH_AY]    = out_item.avg_accel_y;
      got.avg[CH_AZ]    = out_item.avg_accel_z;
      got.avg[CH_ROLL]  = out_item.avg_roll;
      got.avg[CH_PITCH] = out_item.avg_pitch;
      got.avg[CH_YAW]   = out_item.avg_yaw;
      got.yaw_now       = out_item.yaw_now;
      if (pending_averages.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] unexpected result item, yaw_now %0d", $realtime, got.yaw_now);
      end else begin
        want = pending_averages.pop_front();
        bad  = 1'b0;
        for (int c = 0; c < CH; c++) begin
          if (got.avg[c] !== want.avg[c]) begin
            bad = 1'b1;
            if (mismatches < MAX_REPORTS)
              $display("[%0t] result %0d %s: expected %0d, got %0d", $realtime,
                       results_checked, chan_name[c], want.avg[c], got.avg[c]);
          end
        end
        if (got.yaw_now !== want.yaw_now) begin
          bad = 1'b1;
          if (mismatches < MAX_REPORTS)
            $display("[%0t] result %0d yaw_now: expected %0d, got %0d", $realtime,
                     results_checked, want.yaw_now, got.yaw_now);
        end
        if (bad) mismatches++;
      end
    end
  end

  // ends the run if nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_item.valid === 1'b1 && in_item.ready === 1'b1) ||
        (out_item.valid === 1'b1 && out_item.ready === 1'b1)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("stalled for %0d cycles with %0d results outstanding",
               stall_cycles, pending_averages.size());
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule

// ----- sim.f -----
hdl/yima_pkg.sv
hdl/yima_if.sv
hdl/yaw_integrate_moving_average_unit.sv
test/testbench.sv
